### src/delta_list_sleep_queue_macros.svh
// Assertion macros shared by the checker of the delta-list sleep queue.
// Included by bare file name; depends on nothing else.
`ifndef DELTA_LIST_SLEEP_QUEUE_MACROS_SVH
`define DELTA_LIST_SLEEP_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DLSQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DLSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### src/dlsq_pkg.sv
// Types and constants of the delta-list sleep queue.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dlsq_pkg;

    localparam int MAX_SLEEPERS_DEF = 16;
    localparam int DELTA_W = 16;
    localparam int ID_W = 8;

    localparam logic MODE_SLEEP = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_WOKEN    = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   proc_id;
        logic [DELTA_W-1:0] sleep_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] woken_id;
        logic            last;
    } t_out;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [ID_W-1:0]    id;
    } t_entry;

endpackage

`default_nettype wire

### src/dlsq_ram.sv
// Entry memory of the sleep queue: one write port, one read port, registered read.
// Depends on dlsq_pkg for the entry type.
`default_nettype none

module dlsq_ram #(
    parameter int AW = 4
) (
    input  wire               i_clk,
    input  wire               i_we,
    input  wire [AW-1:0]      i_waddr,
    input  dlsq_pkg::t_entry  i_wdata,
    input  wire               i_re,
    input  wire [AW-1:0]      i_raddr,
    output dlsq_pkg::t_entry  o_rdata
);

    localparam int DEPTH = 1 << AW;

    dlsq_pkg::t_entry r_mem [DEPTH];
    dlsq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/dlsq_seq.sv
// Sequencer of the sleep queue: walks, shifts and pops the circular entry list.
// Depends on dlsq_pkg; drives the ports of dlsq_ram.
`default_nettype none

module dlsq_seq #(
    parameter int MAX_SLEEPERS = dlsq_pkg::MAX_SLEEPERS_DEF,
    parameter int PW = $clog2(MAX_SLEEPERS),
    parameter int CW = $clog2(MAX_SLEEPERS + 1)
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_acc,
    input  dlsq_pkg::t_in     i_in,
    input  wire               i_slot_free,
    output logic              o_busy,
    output logic              o_emit_valid,
    output dlsq_pkg::t_out    o_emit,
    output logic              o_we,
    output logic [PW-1:0]     o_waddr,
    output dlsq_pkg::t_entry  o_wdata,
    output logic              o_re,
    output logic [PW-1:0]     o_raddr,
    input  dlsq_pkg::t_entry  i_rd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FIX   = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_TKCHK = 3'd5;
    localparam logic [2:0] S_PEEK  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [CW-1:0] C_MAX = CW'(MAX_SLEEPERS);
    localparam logic [PW-1:0] P_ONE = PW'(1);
    localparam logic [dlsq_pkg::DELTA_W-1:0] D_ONE = dlsq_pkg::DELTA_W'(1);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_occ, n_occ;
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_src, n_src;
    logic [dlsq_pkg::DELTA_W-1:0] r_rem, n_rem;
    logic [dlsq_pkg::ID_W-1:0]    r_pid, n_pid;
    dlsq_pkg::t_entry r_nxt, n_nxt;
    logic [1:0]    r_kind, n_kind;
    logic [dlsq_pkg::ID_W-1:0]    r_id, n_id;
    logic          r_last, n_last;

    logic [dlsq_pkg::DELTA_W-1:0] tk_delta;
    logic [CW-1:0] pos_inc;

    assign tk_delta = (i_rd.delta != '0) ? (i_rd.delta - D_ONE) : '0;
    assign pos_inc  = r_pos + C_ONE;
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_head  = r_head;
        n_pos   = r_pos;
        n_src   = r_src;
        n_rem   = r_rem;
        n_pid   = r_pid;
        n_nxt   = r_nxt;
        n_kind  = r_kind;
        n_id    = r_id;
        n_last  = r_last;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = '0;
        o_emit_valid = 1'b0;
        o_emit  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    if (i_in.mode == dlsq_pkg::MODE_TICK) begin
                        if (r_occ == '0) begin
                            n_kind  = dlsq_pkg::KIND_NONE;
                            n_id    = '0;
                            n_last  = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = r_head;
                            n_state = S_TKCHK;
                        end
                    end else begin
                        n_pid = i_in.proc_id;
                        n_rem = (i_in.sleep_ticks == '0) ? D_ONE : i_in.sleep_ticks;
                        n_pos = '0;
                        if (r_occ == C_MAX) begin
                            n_kind  = dlsq_pkg::KIND_FULL;
                            n_id    = i_in.proc_id;
                            n_last  = 1'b1;
                            n_state = S_EMIT;
                        end else if (r_occ == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = r_head;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (i_rd.delta <= r_rem) begin
                    n_rem = r_rem - i_rd.delta;
                    n_pos = pos_inc;
                    if (pos_inc == r_occ) begin
                        n_state = S_PLACE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_head + pos_inc[PW-1:0];
                    end
                end else begin
                    n_nxt.delta = i_rd.delta - r_rem;
                    n_nxt.id    = i_rd.id;
                    if (pos_inc < r_occ) begin
                        n_src   = r_occ - C_ONE;
                        o_re    = 1'b1;
                        o_raddr = r_head + r_occ[PW-1:0] - P_ONE;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_FIX;
                    end
                end
            end
            S_SHIFT: begin
                o_we    = 1'b1;
                o_waddr = r_head + r_src[PW-1:0] + P_ONE;
                o_wdata = i_rd;
                if (r_src == pos_inc) begin
                    n_state = S_FIX;
                end else begin
                    n_src   = r_src - C_ONE;
                    o_re    = 1'b1;
                    o_raddr = r_head + r_src[PW-1:0] - P_ONE;
                end
            end
            S_FIX: begin
                o_we    = 1'b1;
                o_waddr = r_head + pos_inc[PW-1:0];
                o_wdata = r_nxt;
                n_state = S_PLACE;
            end
            S_PLACE: begin
                o_we          = 1'b1;
                o_waddr       = r_head + r_pos[PW-1:0];
                o_wdata.delta = r_rem;
                o_wdata.id    = r_pid;
                n_occ   = r_occ + C_ONE;
                n_kind  = dlsq_pkg::KIND_ACCEPTED;
                n_id    = r_pid;
                n_last  = 1'b1;
                n_state = S_EMIT;
            end
            S_TKCHK: begin
                if (tk_delta != '0) begin
                    o_we          = 1'b1;
                    o_waddr       = r_head;
                    o_wdata.delta = tk_delta;
                    o_wdata.id    = i_rd.id;
                    n_kind  = dlsq_pkg::KIND_NONE;
                    n_id    = '0;
                    n_last  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_kind = dlsq_pkg::KIND_WOKEN;
                    n_id   = i_rd.id;
                    n_head = r_head + P_ONE;
                    n_occ  = r_occ - C_ONE;
                    if (r_occ == C_ONE) begin
                        n_last  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_last  = 1'b0;
                        o_re    = 1'b1;
                        o_raddr = r_head + P_ONE;
                        n_state = S_PEEK;
                    end
                end
            end
            S_PEEK: begin
                if (i_rd.delta == '0) begin
                    if (i_slot_free) begin
                        o_emit_valid    = 1'b1;
                        o_emit.kind     = dlsq_pkg::KIND_WOKEN;
                        o_emit.woken_id = r_id;
                        o_emit.last     = 1'b0;
                        n_id   = i_rd.id;
                        n_head = r_head + P_ONE;
                        n_occ  = r_occ - C_ONE;
                        if (r_occ == C_ONE) begin
                            n_last  = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = r_head + P_ONE;
                        end
                    end
                end else begin
                    n_last  = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_slot_free) begin
                    o_emit_valid    = 1'b1;
                    o_emit.kind     = r_kind;
                    o_emit.woken_id = r_id;
                    o_emit.last     = r_last;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_head  <= n_head;
        end
        r_pos  <= n_pos;
        r_src  <= n_src;
        r_rem  <= n_rem;
        r_pid  <= n_pid;
        r_nxt  <= n_nxt;
        r_kind <= n_kind;
        r_id   <= n_id;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

### src/delta_list_sleep_queue.sv
// Top level of the delta-list sleep queue: handshakes and result register.
// Depends on dlsq_pkg, dlsq_seq and dlsq_ram.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_stall    | i_in  (mode, proc_id, sleep_ticks)
//   out     | output    | o_out_valid / i_out_stall  | o_out (kind, woken_id, last)
//
// A sleep request walks the entries before its place and shifts those after it one at a
// time through the memory's single read port; a refused request goes straight to its result.
// A tick decrements the head entry or pops each entry whose delta is zero, one report per
// process woken; an output stall holds the sequencer back while a result waits to be taken.
// Reset clears the occupancy and head pointer at once; no memory clearing pass is needed.
// A result waits in the output register while the next item is accepted.
`default_nettype none

module delta_list_sleep_queue #(
    parameter int MAX_SLEEPERS = dlsq_pkg::MAX_SLEEPERS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  dlsq_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output dlsq_pkg::t_out  o_out
);

    localparam int PW = $clog2(MAX_SLEEPERS);
    localparam int CW = $clog2(MAX_SLEEPERS + 1);

    logic             busy;
    logic             in_acc;
    logic             slot_free;
    logic             emit_valid;
    dlsq_pkg::t_out   emit;
    logic             we;
    logic [PW-1:0]    waddr;
    dlsq_pkg::t_entry wdata;
    logic             re;
    logic [PW-1:0]    raddr;
    dlsq_pkg::t_entry rdata;

    logic             r_out_valid;
    dlsq_pkg::t_out   r_out;

    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !busy;
    assign slot_free  = !r_out_valid || !i_out_stall;

    dlsq_seq #(
        .MAX_SLEEPERS (MAX_SLEEPERS),
        .PW           (PW),
        .CW           (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_acc     (in_acc),
        .i_in         (i_in),
        .i_slot_free  (slot_free),
        .o_busy       (busy),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rd         (rdata)
    );

    dlsq_ram #(
        .AW (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= emit_valid;
        end
        if (slot_free && emit_valid) begin
            r_out <= emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### src/dlsq_checker.sv
// Port-level checker of the delta-list sleep queue and its bind to the top level.
// Depends on dlsq_pkg and delta_list_sleep_queue_macros.svh.
`default_nettype none
`include "delta_list_sleep_queue_macros.svh"

module dlsq_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_stall,
    input wire            o_out_valid,
    input wire            i_out_stall,
    input dlsq_pkg::t_out o_out
);

    logic in_acc;
    logic single_kind;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign single_kind = (o_out.kind == dlsq_pkg::KIND_ACCEPTED) ||
                         (o_out.kind == dlsq_pkg::KIND_FULL) ||
                         (o_out.kind == dlsq_pkg::KIND_NONE);

    `DLSQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
    `DLSQ_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall)
    `DLSQ_ASSERT_IMPL(a_single_is_last, o_out_valid && single_kind, o_out.last)
    `DLSQ_ASSERT_IMPL(a_none_zero_id, o_out_valid && (o_out.kind == dlsq_pkg::KIND_NONE), o_out.woken_id == '0)

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (.*);

`default_nettype wire

### tb/sv/tb_delta_list_sleep_queue.sv
// Testbench of delta_list_sleep_queue: directed and random sleep and tick items are checked
// against a behavioral delta list kept in the testbench, with random idling on both sides.
// Depends on dlsq_pkg and the delta_list_sleep_queue RTL.
`timescale 1ns / 100ps

module tb_delta_list_sleep_queue;

    localparam int DEPTH = dlsq_pkg::MAX_SLEEPERS_DEF;
    localparam int DW = dlsq_pkg::DELTA_W;
    localparam int IW = dlsq_pkg::ID_W;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    dlsq_pkg::t_in in_item = '0;
    logic in_stall;
    logic out_valid;
    dlsq_pkg::t_out out_report;

    int in_gap_max = 0;
    int out_gap_max = 0;
    int stall_left = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int cycle_count = 0;

    // Behavioral copy of the sleep list and the reports it has yet to give.
    logic [DW-1:0] sleeper_delta [DEPTH];
    logic [IW-1:0] sleeper_id [DEPTH];
    int sleeper_count = 0;
    dlsq_pkg::t_out reports_due [$];

    delta_list_sleep_queue #(
        .MAX_SLEEPERS(DEPTH)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out(out_report)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic int draw_gap(input int max_gap);
        return (max_gap == 0) ? 0 : int'($urandom_range(max_gap, 0));
    endfunction

    function automatic void expect_report(input logic [1:0] kind, input logic [IW-1:0] id,
                                          input logic last);
        dlsq_pkg::t_out r;
        r.kind = kind;
        r.woken_id = id;
        r.last = last;
        reports_due.push_back(r);
    endfunction

    function automatic void advance_sleep_list(input dlsq_pkg::t_in item);
        logic [DW-1:0] rem;
        int pos;
        int j;
        int woken;
        if (item.mode == dlsq_pkg::MODE_SLEEP) begin
            if (sleeper_count >= DEPTH) begin
                expect_report(dlsq_pkg::KIND_FULL, item.proc_id, 1'b1);
            end else begin
                rem = (item.sleep_ticks == '0) ? DW'(1) : item.sleep_ticks;
                pos = 0;
                while (pos < sleeper_count && sleeper_delta[pos] <= rem) begin
                    rem = rem - sleeper_delta[pos];
                    pos++;
                end
                for (j = sleeper_count; j > pos; j--) begin
                    sleeper_delta[j] = sleeper_delta[j-1];
                    sleeper_id[j] = sleeper_id[j-1];
                end
                sleeper_delta[pos] = rem;
                sleeper_id[pos] = item.proc_id;
                sleeper_count++;
                if (pos + 1 < sleeper_count) begin
                    sleeper_delta[pos+1] = sleeper_delta[pos+1] - rem;
                end
                expect_report(dlsq_pkg::KIND_ACCEPTED, item.proc_id, 1'b1);
            end
        end else begin
            woken = 0;
            if (sleeper_count > 0 && sleeper_delta[0] != '0) begin
                sleeper_delta[0] = sleeper_delta[0] - 1'b1;
            end
            while (sleeper_count > 0 && sleeper_delta[0] == '0) begin
                expect_report(dlsq_pkg::KIND_WOKEN, sleeper_id[0], 1'b0);
                woken++;
                for (j = 1; j < sleeper_count; j++) begin
                    sleeper_delta[j-1] = sleeper_delta[j];
                    sleeper_id[j-1] = sleeper_id[j];
                end
                sleeper_count--;
            end
            if (woken == 0) begin
                expect_report(dlsq_pkg::KIND_NONE, '0, 1'b1);
            end else begin
                reports_due[reports_due.size()-1].last = 1'b1;
            end
        end
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function automatic void check_report(input dlsq_pkg::t_out got);
        dlsq_pkg::t_out want;
        if (reports_due.size() == 0) begin
            note_mismatch("unexpected report (kind)", -1, got.kind);
            return;
        end
        want = reports_due.pop_front();
        if (got.kind !== want.kind) note_mismatch("kind", want.kind, got.kind);
        if (got.woken_id !== want.woken_id) note_mismatch("woken_id", want.woken_id, got.woken_id);
        if (got.last !== want.last) note_mismatch("last", want.last, got.last);
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                check_report(out_report);
                stall_left = draw_gap(out_gap_max);
                out_stall <= (stall_left != 0);
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic mode, input logic [IW-1:0] id,
                             input logic [DW-1:0] ticks);
        int gap;
        dlsq_pkg::t_in item;
        gap = draw_gap(in_gap_max);
        item.mode = mode;
        item.proc_id = id;
        item.sleep_ticks = ticks;
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_item <= dlsq_pkg::t_in'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_sleep_list(item);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(dlsq_pkg::MODE_TICK, IW'($urandom), DW'($urandom));
    endtask

    task automatic test_empty_tick_and_zero_sleep();
        in_gap_max = 3;
        out_gap_max = 3;
        send_tick();
        send_item(dlsq_pkg::MODE_SLEEP, 8'h00, 16'd0);
    endtask

    task automatic test_full_queue_and_mass_wake();
        int k;
        for (k = 1; k < DEPTH; k++) begin
            send_item(dlsq_pkg::MODE_SLEEP, (k == DEPTH - 1) ? 8'hFF : IW'(k), 16'd1);
        end
        send_item(dlsq_pkg::MODE_SLEEP, 8'h77, 16'd5);
        send_tick();
    endtask

    task automatic test_equal_deadlines_and_long_sleep();
        send_item(dlsq_pkg::MODE_SLEEP, 8'h5A, 16'd3);
        send_item(dlsq_pkg::MODE_SLEEP, 8'hA5, 16'd3);
        send_tick();
        send_tick();
        send_tick();
        send_item(dlsq_pkg::MODE_SLEEP, 8'h80, 16'hFFFF);
        send_tick();
    endtask

    task automatic random_sleep();
        logic [DW-1:0] ticks;
        ticks = ($urandom_range(39, 0) == 0) ? DW'($urandom)
                                             : DW'($urandom_range(12, 0));
        send_item(dlsq_pkg::MODE_SLEEP, IW'($urandom), ticks);
    endtask

    task automatic run_random_items(input int count);
        int stop_at;
        int n;
        int k;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(9, 0) < 7) begin
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 8) : $urandom_range(8, 1);
                for (k = 0; k < n; k++) random_sleep();
                n = $urandom_range(16, 1);
                for (k = 0; k < n; k++) send_tick();
            end else if ($urandom_range(1, 0) == 0) begin
                random_sleep();
            end else begin
                send_tick();
            end
        end
    endtask

    task automatic test_random_paced();
        in_gap_max = 11;
        out_gap_max = 11;
        run_random_items(180);
    endtask

    task automatic test_random_back_to_back();
        in_gap_max = 0;
        out_gap_max = 0;
        run_random_items(60);
        in_gap_max = 0;
        out_gap_max = 11;
        run_random_items(30);
        in_gap_max = 11;
        out_gap_max = 0;
        run_random_items(30);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_tick_and_zero_sleep();
        test_full_queue_and_mass_wake();
        test_equal_deadlines_and_long_sleep();
        test_random_paced();
        test_random_back_to_back();
        in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
